[rtl/dstwr_pkg.sv]
// ============================================================================
// dstwr_pkg : shared types and constants for the two-way ranging block
// Widths, scale constants and the queue entry type between front and back.
// ============================================================================
package dstwr_pkg;
   localparam int unsigned IvlWidth = 32;
   localparam int unsigned SumWidth = 34;
   localparam int unsigned ProdWidth = 64;
   localparam int unsigned NumWidth = 65;
   localparam int unsigned TickWidth = 33;
   localparam int unsigned RangeWidth = 51;
   localparam int unsigned RemWidth = 22;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrWidth = 1;
   localparam int unsigned QueueCntWidth = 2;

   // 1565 * 299702547 = 469034 * 1000000 + 486055, so the range is
   // mag * RangeWhole + floor(mag * RangePart / 1000000)
   localparam logic [18:0] RangeWhole = 19'd469034;
   localparam logic [18:0] RangePart = 19'd486055;
   // floor(2^51 / 1000000): estimate of the quotient from the top 31 bits
   localparam logic [31:0] RangeRecip = 32'd2251799813;
   localparam logic [19:0] RangeDivisor = 20'd1000000;
   localparam logic [RemWidth-1:0] RangeDivisor2 = 22'd2000000;
   localparam logic [RemWidth-1:0] RangeDivisor3 = 22'd3000000;

   // Request after interval forming, waiting in the queue
   typedef struct packed {
      logic [IvlWidth-1:0] ra;
      logic [IvlWidth-1:0] rb;
      logic [IvlWidth-1:0] da;
      logic [IvlWidth-1:0] db;
   } ivl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_POS,
      ST_MUL_NEG,
      ST_SUB,
      ST_DIV,
      ST_SCALE_A,
      ST_SCALE_B,
      ST_SCALE_C,
      ST_FIX,
      ST_DONE
   } back_state_type;
endpackage

[rtl/dstwr_front.sv]
// ============================================================================
// dstwr_front : interval forming and request queue
// Takes a request, forms the four wrapping intervals, holds them in a queue.
// ============================================================================
module dstwr_front import dstwr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_remote_poll_sent,
   input  logic [31:0] req_remote_reply_heard,
   input  logic [31:0] req_remote_final_sent,
   input  logic [39:0] req_local_poll_heard,
   input  logic [39:0] req_local_reply_sent,
   input  logic [39:0] req_local_final_heard,
   output logic        q_valid,
   input  logic        q_take,
   output ivl_type     q_data
);
   ivl_type q_mem_ff [QueueDepth];
   ivl_type q_mem_in;
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == QueueCntWidth'(QueueDepth));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_take;
   assign q_data = q_mem_ff[rd_ptr_ff];

   always_comb begin
      q_mem_in.ra = req_remote_reply_heard - req_remote_poll_sent;
      q_mem_in.rb = req_local_final_heard[31:0] - req_local_reply_sent[31:0];
      q_mem_in.da = req_remote_final_sent - req_remote_reply_heard;
      q_mem_in.db = req_local_reply_sent[31:0] - req_local_poll_heard[31:0];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= q_mem_in;
      end
   end
endmodule

[rtl/dstwr_divider.sv]
// ============================================================================
// dstwr_divider : restoring divider for the flight quotient
// One quotient bit per cycle, 65-bit dividend over a 34-bit divisor.
// ============================================================================
module dstwr_divider import dstwr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] dividend,
   input  logic [SumWidth-1:0] divisor,
   output logic                done,
   output logic [NumWidth-1:0] quotient
);
   logic [NumWidth-1:0] quo_ff, quo_in;
   logic [SumWidth-1:0] rem_ff, rem_in;
   logic [SumWidth-1:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [SumWidth:0] trial;

   assign done = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[NumWidth-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = SumWidth'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[SumWidth-1:0];
            quo_in = {quo_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

[rtl/dstwr_back.sv]
// ============================================================================
// dstwr_back : time-of-flight and range sequencer
// Multiplies, divides and scales one request at a time, output register.
// ============================================================================
module dstwr_back import dstwr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  ivl_type               q_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TickWidth-1:0]  rsp_flight_ticks,
   output logic [RangeWidth-1:0] rsp_range_value,
   output logic                  rsp_below_zero,
   output logic                  rsp_bad_sum
);
   back_state_type state_ff, state_in;
   ivl_type ivl_ff, ivl_in;
   logic [SumWidth-1:0] sum_ff, sum_in;
   logic [ProdWidth-1:0] pos_ff, pos_in, neg_ff, neg_in;
   logic neg_sign_ff, neg_sign_in;
   logic [IvlWidth-1:0] mag_ff, mag_in;
   logic [RangeWidth-1:0] whole_ff, whole_in, part_ff, part_in;
   logic [IvlWidth-1:0] qe_ff, qe_in;
   logic [RemWidth-1:0] rem_ff, rem_in;
   logic [1:0] fix;
   logic [TickWidth-1:0] res_ticks_ff, res_ticks_in;
   logic [RangeWidth-1:0] res_range_ff, res_range_in;
   logic res_below_ff, res_below_in, res_bad_ff, res_bad_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [TickWidth-1:0] ticks_ff, ticks_in;
   logic [RangeWidth-1:0] range_ff, range_in;
   logic below_ff, below_in, bad_ff, bad_in;
   logic div_start;
   logic [NumWidth-1:0] div_dividend;
   logic div_done;
   logic [NumWidth-1:0] div_quo;
   logic out_free;

   dstwr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(sum_ff), .done(div_done), .quotient(div_quo)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_flight_ticks = ticks_ff;
   assign rsp_range_value = range_ff;
   assign rsp_below_zero = below_ff;
   assign rsp_bad_sum = bad_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (q_valid) state_in = ST_MUL_POS;
         ST_MUL_POS: state_in = (sum_ff == '0) ? ST_DONE : ST_MUL_NEG;
         ST_MUL_NEG: state_in = ST_SUB;
         ST_SUB:     state_in = ST_DIV;
         ST_DIV:     if (div_done) state_in = ST_SCALE_A;
         ST_SCALE_A: state_in = ST_SCALE_B;
         ST_SCALE_B: state_in = ST_SCALE_C;
         ST_SCALE_C: state_in = ST_FIX;
         ST_FIX:     state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ivl_in = ivl_ff;
      sum_in = sum_ff;
      pos_in = pos_ff;
      neg_in = neg_ff;
      neg_sign_in = neg_sign_ff;
      mag_in = mag_ff;
      whole_in = whole_ff;
      part_in = part_ff;
      qe_in = qe_ff;
      rem_in = rem_ff;
      res_ticks_in = res_ticks_ff;
      res_range_in = res_range_ff;
      res_below_in = res_below_ff;
      res_bad_in = res_bad_ff;
      ticks_in = ticks_ff;
      range_in = range_ff;
      below_in = below_ff;
      bad_in = bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_take = 1'b0;
      div_start = 1'b0;
      div_dividend = neg_ff > pos_ff ? NumWidth'(neg_ff - pos_ff)
                                     : NumWidth'(pos_ff - neg_ff);
      // the estimate is at most three below the true quotient
      if (rem_ff >= RangeDivisor3) fix = 2'd3;
      else if (rem_ff >= RangeDivisor2) fix = 2'd2;
      else if (rem_ff >= RemWidth'(RangeDivisor)) fix = 2'd1;
      else fix = 2'd0;
      case (state_ff)
         ST_IDLE: begin
            q_take = q_valid;
            ivl_in = q_data;
            sum_in = SumWidth'(q_data.ra) + SumWidth'(q_data.rb)
                   + SumWidth'(q_data.da) + SumWidth'(q_data.db);
         end
         ST_MUL_POS: begin
            pos_in = ivl_ff.ra * ivl_ff.rb;
            if (sum_ff == '0) begin
               res_ticks_in = '0;
               res_range_in = '0;
               res_below_in = 1'b0;
               res_bad_in = 1'b1;
            end
         end
         ST_MUL_NEG: neg_in = ivl_ff.da * ivl_ff.db;
         ST_SUB: begin
            neg_sign_in = neg_ff > pos_ff;
            div_start = 1'b1;
         end
         ST_DIV: if (div_done) mag_in = div_quo[IvlWidth-1:0];
         ST_SCALE_A: begin
            whole_in = RangeWidth'(mag_ff) * RangeWidth'(RangeWhole);
            part_in = RangeWidth'(mag_ff) * RangeWidth'(RangePart);
         end
         ST_SCALE_B: begin
            // estimate part / 1000000 from its top 31 bits
            qe_in = IvlWidth'((63'(part_ff[50:20]) * 63'(RangeRecip)) >> 31);
         end
         ST_SCALE_C: begin
            rem_in = RemWidth'(part_ff - RangeWidth'(qe_ff) * RangeWidth'(RangeDivisor));
         end
         ST_FIX: begin
            res_below_in = neg_sign_ff && (mag_ff != '0);
            res_bad_in = 1'b0;
            res_ticks_in = res_below_in ? TickWidth'(0) - TickWidth'(mag_ff)
                                        : TickWidth'(mag_ff);
            res_range_in = res_below_in ? '0
                         : whole_ff + RangeWidth'(qe_ff + IvlWidth'(fix));
         end
         ST_DONE: begin
            // load the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ticks_in = res_ticks_ff;
               range_in = res_range_ff;
               below_in = res_below_ff;
               bad_in = res_bad_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ivl_ff <= ivl_in;
      sum_ff <= sum_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      neg_sign_ff <= neg_sign_in;
      mag_ff <= mag_in;
      whole_ff <= whole_in;
      part_ff <= part_in;
      qe_ff <= qe_in;
      rem_ff <= rem_in;
      res_ticks_ff <= res_ticks_in;
      res_range_ff <= res_range_in;
      res_below_ff <= res_below_in;
      res_bad_ff <= res_bad_in;
      ticks_ff <= ticks_in;
      range_ff <= range_in;
      below_ff <= below_in;
      bad_ff <= bad_in;
   end
endmodule

[rtl/ds_twr_time_of_flight.sv]
// Each request passes the multiplies, the subtraction, the 65-step division,
// scaling and fix; with all four intervals zero it skips straight to done.
// The back end takes a new request only after loading its output register.
// A two-entry request queue accepts new requests while the back end works.
// Reset: synchronous, active high; clears queue, sequencer and response valid.
// ============================================================================
// ds_twr_time_of_flight : double-sided two-way ranging time of flight
// Forms intervals, computes exact truncated time of flight and scaled range.
// ============================================================================
module ds_twr_time_of_flight import dstwr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_remote_poll_sent,
   input  logic [31:0] req_remote_reply_heard,
   input  logic [31:0] req_remote_final_sent,
   input  logic [39:0] req_local_poll_heard,
   input  logic [39:0] req_local_reply_sent,
   input  logic [39:0] req_local_final_heard,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [32:0] rsp_flight_ticks,
   output logic [50:0] rsp_range_value,
   output logic        rsp_below_zero,
   output logic        rsp_bad_sum
);
   logic q_valid, q_take;
   ivl_type q_data;
   logic [TickWidth-1:0] ticks;

   // front: accept request, form intervals, queue
   dstwr_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_remote_poll_sent(req_remote_poll_sent),
      .req_remote_reply_heard(req_remote_reply_heard),
      .req_remote_final_sent(req_remote_final_sent),
      .req_local_poll_heard(req_local_poll_heard),
      .req_local_reply_sent(req_local_reply_sent),
      .req_local_final_heard(req_local_final_heard),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   // back: multiply, divide, scale, hold result until taken
   dstwr_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_data(q_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_flight_ticks(ticks), .rsp_range_value(rsp_range_value),
      .rsp_below_zero(rsp_below_zero), .rsp_bad_sum(rsp_bad_sum)
   );

   assign rsp_flight_ticks = signed'(ticks);
endmodule

[rtl/dstwr_checker.sv]
// ============================================================================
// dstwr_checker : port-level checks for the ranging block
// Watches the response channel and the flags it carries.
// ============================================================================
module dstwr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [32:0] rsp_flight_ticks,
   input logic [50:0] rsp_range_value,
   input logic        rsp_below_zero,
   input logic        rsp_bad_sum
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_flight_ticks))
      else $error("response dropped while stalled");
   a_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_below_zero |-> rsp_range_value == '0 && rsp_flight_ticks[32])
      else $error("negative flight with range");
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_sum |-> rsp_flight_ticks == '0 && !rsp_below_zero)
      else $error("bad sum with nonzero result");
endmodule

bind ds_twr_time_of_flight dstwr_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_flight_ticks(rsp_flight_ticks), .rsp_range_value(rsp_range_value),
   .rsp_below_zero(rsp_below_zero), .rsp_bad_sum(rsp_bad_sum)
);

[bench/tb_ds_twr_time_of_flight.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_ds_twr_time_of_flight : self-checking bench for the ranging time of flight
// Drives timestamp sets of ranging exchanges with random idling on both sides.
// Predicts time of flight, range and flags per request, and checks in order.
// ============================================================================
module tb_ds_twr_time_of_flight import dstwr_pkg::*; ();

   // One ranging exchange. A set pause bit makes the sender wait for every
   // pending response before offering it.
   typedef struct {
      logic [31:0] r_poll;
      logic [31:0] r_reply;
      logic [31:0] r_final;
      logic [39:0] l_poll;
      logic [39:0] l_reply;
      logic [39:0] l_final;
      bit          pause;
   } exchange_type;

   typedef struct {
      logic signed [TickWidth-1:0] ticks;
      logic [RangeWidth-1:0]       range;
      logic                        negative;
      logic                        bad;
   } flight_type;

   localparam int IdleLimit = 5000;
   localparam int LongHold = 400;
   localparam int RandomCount = 1700;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_remote_poll_sent;
   logic [31:0] req_remote_reply_heard;
   logic [31:0] req_remote_final_sent;
   logic [39:0] req_local_poll_heard;
   logic [39:0] req_local_reply_sent;
   logic [39:0] req_local_final_heard;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [32:0] rsp_flight_ticks;
   logic [50:0] rsp_range_value;
   logic        rsp_below_zero;
   logic        rsp_bad_sum;

   exchange_type exchange_q[$];   // requests waiting to be offered
   flight_type   flight_q[$];     // predicted responses, oldest first

   int  errors = 0;
   int  requests_sent = 0;
   int  responses_seen = 0;
   int  negative_seen = 0;
   int  bad_seen = 0;
   int  idle_cycles = 0;
   bit  req_taken = 0;
   bit  rsp_taken = 0;
   bit  long_hold_done = 0;

   ds_twr_time_of_flight i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_remote_poll_sent   (req_remote_poll_sent),
      .req_remote_reply_heard (req_remote_reply_heard),
      .req_remote_final_sent  (req_remote_final_sent),
      .req_local_poll_heard   (req_local_poll_heard),
      .req_local_reply_sent   (req_local_reply_sent),
      .req_local_final_heard  (req_local_final_heard),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_flight_ticks       (rsp_flight_ticks),
      .rsp_range_value        (rsp_range_value),
      .rsp_below_zero         (rsp_below_zero),
      .rsp_bad_sum            (rsp_bad_sum)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Time of flight from the four wrapped intervals, exact and truncated
   // toward zero; range scaled by tick length and light speed.
   function automatic flight_type compute_flight(exchange_type x);
      logic [31:0]  ra, rb, da, db;
      logic [33:0]  denom;
      logic [63:0]  pos, neg, mag;
      logic [127:0] scaled;
      flight_type   f;
      ra = x.r_reply - x.r_poll;
      rb = x.l_final[31:0] - x.l_reply[31:0];
      da = x.r_final - x.r_reply;
      db = x.l_reply[31:0] - x.l_poll[31:0];
      denom = {2'b00, ra} + rb + da + db;
      pos = {32'd0, ra} * rb;
      neg = {32'd0, da} * db;
      f.ticks = '0;
      f.range = '0;
      f.negative = 1'b0;
      f.bad = 1'b0;
      if (denom == 0) begin
         f.bad = 1'b1;
      end else if (neg > pos) begin
         // a small negative numerator can truncate to zero: no flag then
         mag = (neg - pos) / denom;
         f.negative = (mag != 0);
         f.ticks = -$signed({1'b0, mag[31:0]});
      end else begin
         mag = (pos - neg) / denom;
         f.ticks = $signed({1'b0, mag[31:0]});
         scaled = {96'd0, mag[31:0]} * 128'd1565;
         scaled = scaled * 128'd299 + (scaled * 128'd702547) / 128'd1000000;
         f.range = scaled[50:0];
      end
      return f;
   endfunction

   // Build an exchange from its four intervals and the remote and local clock bases.
   function automatic exchange_type make_exchange(logic [31:0] ra, logic [31:0] rb,
                                                  logic [31:0] da, logic [31:0] db,
                                                  logic [31:0] r_base,
                                                  logic [31:0] l_base,
                                                  logic [23:0] high_bits);
      exchange_type x;
      x.r_poll = r_base;
      x.r_reply = r_base + ra;
      x.r_final = x.r_reply + da;
      x.l_poll = {high_bits[7:0], l_base};
      x.l_reply = {high_bits[15:8], l_base + db};
      x.l_final = {high_bits[23:16], l_base + db + rb};
      x.pause = 1'b0;
      return x;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on response %0d: %s got %0h, want %0h",
               responses_seen, field, got, want);
      errors++;
   endtask

   // Sender: hold a stalled request, else draw a gap and offer the next one.
   int send_gap = 0;
   always @(negedge clock) begin
      exchange_type x;
      logic         next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         next_valid = 1'b0;
         if (req_taken) begin
            requests_sent++;
            // leave a stretch with no sender gaps
            send_gap = (requests_sent > 500 && requests_sent < 700) ? 0 : $urandom_range(0, 6);
         end
         if (send_gap > 0) begin
            send_gap--;
         end else if (exchange_q.size() > 0 &&
                      !(exchange_q[0].pause && flight_q.size() > 0)) begin
            x = exchange_q.pop_front();
            req_remote_poll_sent <= x.r_poll;
            req_remote_reply_heard <= x.r_reply;
            req_remote_final_sent <= x.r_final;
            req_local_poll_heard <= x.l_poll;
            req_local_reply_sent <= x.l_reply;
            req_local_final_heard <= x.l_final;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // Predict on every accepted request.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         exchange_type x;
         x.r_poll = req_remote_poll_sent;
         x.r_reply = req_remote_reply_heard;
         x.r_final = req_remote_final_sent;
         x.l_poll = req_local_poll_heard;
         x.l_reply = req_local_reply_sent;
         x.l_final = req_local_final_heard;
         x.pause = 1'b0;
         flight_q.push_back(compute_flight(x));
      end
   end

   // Receiver: random stall per response, one long hold to fill the block.
   int stall_left = 0;
   int long_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            stall_left = (responses_seen > 1000 && responses_seen < 1300) ? 0 :
                         $urandom_range(0, 6);
         end
         if (responses_seen == 300 && !long_hold_done) begin
            long_hold_done = 1;
            long_left = LongHold;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check each accepted response against the oldest prediction.
   always @(posedge clock) begin
      flight_type f;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flight_q.size() == 0) begin
            $display("response %0d arrived with nothing predicted", responses_seen);
            errors++;
         end else begin
            f = flight_q.pop_front();
            if (rsp_flight_ticks !== f.ticks)
               report_mismatch("flight_ticks", 64'(rsp_flight_ticks), 64'(f.ticks));
            if (rsp_range_value !== f.range)
               report_mismatch("range_value", 64'(rsp_range_value), 64'(f.range));
            if (rsp_below_zero !== f.negative)
               report_mismatch("below_zero", 64'(rsp_below_zero), 64'(f.negative));
            if (rsp_bad_sum !== f.bad)
               report_mismatch("bad_sum", 64'(rsp_bad_sum), 64'(f.bad));
            if (f.negative) negative_seen++;
            if (f.bad) bad_seen++;
         end
         responses_seen++;
      end
   end

   // Watchdog: end the run when neither side moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("no handshake for %0d cycles, %0d responses pending",
                  IdleLimit, flight_q.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      exchange_type x;
      logic [31:0]  tof, reply_a, reply_b;
      int           pick;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_remote_poll_sent = '0;
      req_remote_reply_heard = '0;
      req_remote_final_sent = '0;
      req_local_poll_heard = '0;
      req_local_reply_sent = '0;
      req_local_final_heard = '0;

      // directed: raw extremes of every field
      x = '{default: '0};
      exchange_q.push_back(x);
      x = '{r_poll: '1, r_reply: '1, r_final: '1, l_poll: '1, l_reply: '1,
            l_final: '1, pause: 1'b0};
      exchange_q.push_back(x);
      // zero denominator with high local bits set
      exchange_q.push_back(make_exchange(0, 0, 0, 0, 32'h1234_5678, 32'hFFFF_FFF0, 24'hFF_FF_FF));
      // ordinary positive flight
      exchange_q.push_back(make_exchange(32'd100_000, 32'd90_000, 32'd89_000, 32'd99_000,
                                         32'd5, 32'd777, 24'h01_02_03));
      // negative flight
      exchange_q.push_back(make_exchange(1, 1, 1000, 1000, 0, 0, 24'd0));
      // small negative numerator truncating to zero
      exchange_q.push_back(make_exchange(2, 2, 1, 5, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 24'd0));
      // all intervals at maximum: products cancel
      exchange_q.push_back(make_exchange('1, '1, '1, '1, 32'h8000_0000, 32'd3, 24'hAA_55_AA));
      // largest positive and negative flight
      exchange_q.push_back(make_exchange('1, '1, 0, 0, 32'd17, 32'hFFFF_0000, 24'h55_AA_55));
      exchange_q.push_back(make_exchange(0, 0, '1, '1, 32'hFFFF_FFFF, 32'd9, 24'd0));
      // one interval only, flight zero; then counter wrap in both clocks
      exchange_q.push_back(make_exchange(0, 0, 0, 32'd42, 0, 0, 24'hFF_00_FF));
      exchange_q.push_back(make_exchange(32'd300, 32'd310, 32'd250, 32'd240,
                                         32'hFFFF_FF00, 32'hFFFF_FFC0, 24'h7F_80_7F));
      exchange_q.push_back(make_exchange(32'd1, 32'd1, 32'd1, 32'd1, 0, 0, 24'd0));

      // random: mostly plausible exchanges with a small true flight,
      // the rest arbitrary timestamps and tiny intervals
      for (int i = 0; i < RandomCount; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            tof = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
            reply_a = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24);
            reply_b = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24);
            x = make_exchange(reply_b + 2 * tof + $urandom_range(0, 20),
                              reply_a + 2 * tof + $urandom_range(0, 20),
                              reply_a, reply_b, $urandom, $urandom, 24'($urandom));
         end else if (pick < 9) begin
            x.r_poll = $urandom;
            x.r_reply = $urandom;
            x.r_final = $urandom;
            x.l_poll = {8'($urandom), 32'($urandom)};
            x.l_reply = {8'($urandom), 32'($urandom)};
            x.l_final = {8'($urandom), 32'($urandom)};
            x.pause = 1'b0;
         end else begin
            x = make_exchange($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 3), $urandom, $urandom, 24'($urandom));
         end
         // sender pauses twice until every response is back
         x.pause = (i == 800 || i == 1400);
         exchange_q.push_back(x);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (exchange_q.size() == 0 && !req_valid);
      wait (flight_q.size() == 0);
      repeat (300) @(posedge clock);

      $display("%0d exchanges sent, %0d responses checked", requests_sent, responses_seen);
      $display("%0d negative flights, %0d zero denominators", negative_seen, bad_seen);
      if (errors == 0 && flight_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
